FILE: rtl/fvna_pkg.sv
package fvna_pkg;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_CORNER = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;

  localparam int IDX_BITS  = 10;
  localparam int POS_BITS  = 16;
  localparam int NORM_BITS = 16;
  localparam int POS_PAD   = 24;

  typedef struct packed {
    logic [1:0]                  func;
    logic [IDX_BITS-1:0]         vertex_index;
    logic signed [POS_BITS-1:0]  pos_x;
    logic signed [POS_BITS-1:0]  pos_y;
    logic signed [POS_BITS-1:0]  pos_z;
    logic                        corner_last;
  } req_t;

  typedef struct packed {
    logic signed [NORM_BITS-1:0] normal_x;
    logic signed [NORM_BITS-1:0] normal_y;
    logic signed [NORM_BITS-1:0] normal_z;
    logic [IDX_BITS-1:0]         read_vertex;
    logic                        was_zero;
  } rsp_t;

  typedef struct packed {
    logic                        done;
    logic signed [NORM_BITS-1:0] nx;
    logic signed [NORM_BITS-1:0] ny;
    logic signed [NORM_BITS-1:0] nz;
  } norm_res_t;

endpackage

FILE: rtl/fvna_if.sv
interface fvna_req_if;
  logic          valid;
  logic          ready;
  fvna_pkg::req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface fvna_rsp_if;
  logic          valid;
  logic          ready;
  fvna_pkg::rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/fan_vertex_normal_accumulator_top.sv
// load or plain corner: accepted with no further work; a corner that closes a triangle
// holds the input off (three position reads, three product pairs, three sum read-modify-writes)
// read: the sum is normalized by shifting (at most 29 shifts), then a 32-step square root
// and three 16-step divisions give the response; a zero sum skips the normalizer
// one request at a time; a finished result waits in the output register
// after reset the sum memory is cleared, one entry a cycle, before the first request is taken
module fan_vertex_normal_accumulator_top #(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_BITS   = 16,
  parameter int SUM_BITS     = 40
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  fvna_req_if.sink         req_i,
  fvna_rsp_if.source       rsp_o
);

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int CW = PW + 1;
  localparam int XW = ((SUM_BITS > CW) ? SUM_BITS : CW) + 1;
  localparam logic signed [XW-1:0] SAT_HI = XW'((64'sd1 <<< (SUM_BITS - 1)) - 64'sd1);
  localparam logic signed [XW-1:0] SAT_LO = -SAT_HI - XW'(1);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_PRD   = 4'd2;
  localparam logic [3:0] ST_DIFF  = 4'd3;
  localparam logic [3:0] ST_MUL   = 4'd4;
  localparam logic [3:0] ST_SUB   = 4'd5;
  localparam logic [3:0] ST_SRD   = 4'd6;
  localparam logic [3:0] ST_SWR   = 4'd7;
  localparam logic [3:0] ST_RRD   = 4'd8;
  localparam logic [3:0] ST_RCHK  = 4'd9;
  localparam logic [3:0] ST_RNORM = 4'd10;
  localparam logic [3:0] ST_ROUT  = 4'd11;

  function automatic logic [IW-1:0] wrap_idx(input logic [fvna_pkg::IDX_BITS-1:0] v);
    logic [26:0] rem;
    rem = 27'(v);
    for (int k = fvna_pkg::IDX_BITS - 1; k >= 0; k--) begin
      if (rem >= (27'(MAX_VERTICES) << k)) rem = rem - (27'(MAX_VERTICES) << k);
    end
    return rem[IW-1:0];
  endfunction

  function automatic logic [COORD_BITS-1:0] coord(input logic [fvna_pkg::POS_BITS-1:0] v);
    logic [fvna_pkg::POS_PAD-1:0] w;
    w = fvna_pkg::POS_PAD'(v);
    return w[COORD_BITS-1:0];
  endfunction

  function automatic logic [SUM_BITS-1:0] sat_add(input logic signed [SUM_BITS-1:0] a,
                                                  input logic signed [CW-1:0] b);
    logic signed [XW-1:0] s;
    logic signed [XW-1:0] r;
    s = XW'(a) + XW'(b);
    if (s > SAT_HI) r = SAT_HI;
    else if (s < SAT_LO) r = SAT_LO;
    else r = s;
    return r[SUM_BITS-1:0];
  endfunction

  logic [3:0]    st_q, st_d;
  logic [IW-1:0] clr_q, clr_d, idx_q, idx_d, first_q, first_d, prev_q, prev_d;
  logic [1:0]    seen_q, seen_d, cnt_q, cnt_d;
  logic [IW-1:0] t_q [3];
  logic [IW-1:0] t_d [3];
  logic signed [COORD_BITS-1:0] px_q [3], py_q [3], pz_q [3];
  logic signed [DW-1:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q;
  logic signed [PW-1:0] m1_q, m2_q;
  logic signed [CW-1:0] c_q [3];
  logic signed [fvna_pkg::NORM_BITS-1:0] rx_q, ry_q, rz_q, rx_d, ry_d, rz_d;
  logic          wz_q, wz_d;
  logic          ov_q, ov_d;
  fvna_pkg::rsp_t out_q, out_d;

  logic                     acc;
  logic [IW-1:0]            in_idx;
  logic                     pos_we, sum_we;
  logic [IW-1:0]            pos_ra, sum_ra, sum_wa;
  logic [3*COORD_BITS-1:0]  pos_rd;
  logic [3*SUM_BITS-1:0]    sum_rd, sum_wd;
  logic signed [SUM_BITS-1:0] sx, sy, sz;
  logic signed [DW-1:0]     o1, o2, o3, o4;
  logic                     norm_start;
  fvna_pkg::norm_res_t      nres;

  assign acc    = req_i.valid && req_i.ready;
  assign in_idx = wrap_idx(req_i.data.vertex_index);
  assign req_i.ready = (st_q == ST_IDLE);
  assign sx = sum_rd[3*SUM_BITS-1:2*SUM_BITS];
  assign sy = sum_rd[2*SUM_BITS-1:SUM_BITS];
  assign sz = sum_rd[SUM_BITS-1:0];

  always_comb begin
    case (cnt_q)
      2'd0:    begin o1 = ay_q; o2 = bz_q; o3 = az_q; o4 = by_q; end
      2'd1:    begin o1 = az_q; o2 = bx_q; o3 = ax_q; o4 = bz_q; end
      default: begin o1 = ax_q; o2 = by_q; o3 = ay_q; o4 = bx_q; end
    endcase
  end

  always_comb begin
    pos_we = acc && (req_i.data.func == fvna_pkg::FUNC_LOAD);
    pos_ra = (cnt_q != 2'd3) ? t_q[cnt_q] : '0;
    sum_we = 1'b0;
    sum_wa = in_idx;
    sum_wd = '0;
    sum_ra = (st_q == ST_RRD) ? idx_q : t_q[(cnt_q == 2'd3) ? 2'd0 : cnt_q];
    if (st_q == ST_CLEAR) begin
      sum_we = 1'b1;
      sum_wa = clr_q;
    end else if (pos_we) begin
      sum_we = 1'b1;
    end else if (st_q == ST_SWR) begin
      sum_we = 1'b1;
      sum_wa = t_q[(cnt_q == 2'd3) ? 2'd0 : cnt_q];
      sum_wd = {sat_add(sx, c_q[0]), sat_add(sy, c_q[1]), sat_add(sz, c_q[2])};
    end
  end

  always_comb begin
    st_d = st_q; clr_d = clr_q; idx_d = idx_q; first_d = first_q; prev_d = prev_q;
    seen_d = seen_q; cnt_d = cnt_q; rx_d = rx_q; ry_d = ry_q; rz_d = rz_q; wz_d = wz_q;
    ov_d = ov_q; out_d = out_q; norm_start = 1'b0;
    for (int i = 0; i < 3; i++) t_d[i] = t_q[i];
    if (rsp_o.valid && rsp_o.ready) ov_d = 1'b0;
    case (st_q)
      ST_CLEAR: begin
        clr_d = clr_q + IW'(1);
        if (clr_q == IW'(MAX_VERTICES - 1)) st_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc) begin
          idx_d = in_idx;
          case (req_i.data.func)
            fvna_pkg::FUNC_CORNER: begin
              if (seen_q == 2'd0) begin
                first_d = in_idx;
                seen_d  = 2'd1;
              end else if (seen_q == 2'd1) begin
                prev_d = in_idx;
                seen_d = 2'd2;
              end else begin
                t_d[0] = first_q;
                t_d[1] = prev_q;
                t_d[2] = in_idx;
                prev_d = in_idx;
                cnt_d  = 2'd0;
                st_d   = ST_PRD;
              end
              if (req_i.data.corner_last) seen_d = 2'd0;
            end
            fvna_pkg::FUNC_READ: st_d = ST_RRD;
            default: ;
          endcase
        end
      end
      ST_PRD: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) st_d = ST_DIFF;
      end
      ST_DIFF: begin
        cnt_d = 2'd0;
        st_d  = ST_MUL;
      end
      ST_MUL: st_d = ST_SUB;
      ST_SUB: begin
        if (cnt_q == 2'd2) begin
          cnt_d = 2'd0;
          st_d  = ST_SRD;
        end else begin
          cnt_d = cnt_q + 2'd1;
          st_d  = ST_MUL;
        end
      end
      ST_SRD: st_d = ST_SWR;
      ST_SWR: begin
        if (cnt_q == 2'd2) begin
          st_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 2'd1;
          st_d  = ST_SRD;
        end
      end
      ST_RRD: st_d = ST_RCHK;
      ST_RCHK: begin
        if (sum_rd == '0) begin
          rx_d = '0; ry_d = '0; rz_d = '0;
          wz_d = 1'b1;
          st_d = ST_ROUT;
        end else begin
          norm_start = 1'b1;
          st_d = ST_RNORM;
        end
      end
      ST_RNORM: begin
        if (nres.done) begin
          rx_d = nres.nx; ry_d = nres.ny; rz_d = nres.nz;
          wz_d = 1'b0;
          st_d = ST_ROUT;
        end
      end
      ST_ROUT: begin
        if (!ov_q || rsp_o.ready) begin
          ov_d = 1'b1;
          out_d.normal_x    = rx_q;
          out_d.normal_y    = ry_q;
          out_d.normal_z    = rz_q;
          out_d.read_vertex = fvna_pkg::IDX_BITS'(idx_q);
          out_d.was_zero    = wz_q;
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_CLEAR;
      clr_q  <= '0;
      first_q <= '0;
      prev_q <= '0;
      seen_q <= '0;
      cnt_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      clr_q  <= clr_d;
      first_q <= first_d;
      prev_q <= prev_d;
      seen_q <= seen_d;
      cnt_q  <= cnt_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    rx_q <= rx_d; ry_q <= ry_d; rz_q <= rz_d; wz_q <= wz_d;
    out_q <= out_d;
    for (int i = 0; i < 3; i++) t_q[i] <= t_d[i];
    // position data arrives in the cycle after its read address
    if (st_q == ST_PRD && cnt_q != 2'd0) begin
      px_q[cnt_q - 2'd1] <= pos_rd[3*COORD_BITS-1:2*COORD_BITS];
      py_q[cnt_q - 2'd1] <= pos_rd[2*COORD_BITS-1:COORD_BITS];
      pz_q[cnt_q - 2'd1] <= pos_rd[COORD_BITS-1:0];
    end
    if (st_q == ST_DIFF) begin
      ax_q <= DW'(px_q[1]) - DW'(px_q[0]);
      ay_q <= DW'(py_q[1]) - DW'(py_q[0]);
      az_q <= DW'(pz_q[1]) - DW'(pz_q[0]);
      bx_q <= DW'(px_q[2]) - DW'(px_q[0]);
      by_q <= DW'(py_q[2]) - DW'(py_q[0]);
      bz_q <= DW'(pz_q[2]) - DW'(pz_q[0]);
    end
    if (st_q == ST_MUL) begin
      m1_q <= PW'(o1) * PW'(o2);
      m2_q <= PW'(o3) * PW'(o4);
    end
    if (st_q == ST_SUB) begin
      c_q[(cnt_q == 2'd3) ? 2'd0 : cnt_q] <= CW'(m1_q) - CW'(m2_q);
    end
  end

  assign rsp_o.valid = ov_q;
  assign rsp_o.data  = out_q;

  fvna_ram #(
    .WIDTH(3 * COORD_BITS),
    .DEPTH(MAX_VERTICES)
  ) u_pos_ram (
    .clk_i  (clk_i),
    .we_i   (pos_we),
    .waddr_i(in_idx),
    .wdata_i({coord(req_i.data.pos_x), coord(req_i.data.pos_y), coord(req_i.data.pos_z)}),
    .raddr_i(pos_ra),
    .rdata_o(pos_rd)
  );

  fvna_ram #(
    .WIDTH(3 * SUM_BITS),
    .DEPTH(MAX_VERTICES)
  ) u_sum_ram (
    .clk_i  (clk_i),
    .we_i   (sum_we),
    .waddr_i(sum_wa),
    .wdata_i(sum_wd),
    .raddr_i(sum_ra),
    .rdata_o(sum_rd)
  );

  fvna_norm #(
    .SUM_BITS(SUM_BITS)
  ) u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(norm_start),
    .sum_x_i(sx),
    .sum_y_i(sy),
    .sum_z_i(sz),
    .res_o  (nres)
  );

endmodule

FILE: rtl/fvna_ram.sv
module fvna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/fvna_norm.sv
module fvna_norm #(
  parameter int SUM_BITS = 40
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [SUM_BITS-1:0] sum_x_i,
  input  logic signed [SUM_BITS-1:0] sum_y_i,
  input  logic signed [SUM_BITS-1:0] sum_z_i,
  output fvna_pkg::norm_res_t        res_o
);

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SHIFT = 3'd1;
  localparam logic [2:0] N_SQ    = 3'd2;
  localparam logic [2:0] N_ROOT  = 3'd3;
  localparam logic [2:0] N_DVI   = 3'd4;
  localparam logic [2:0] N_DIV   = 3'd5;
  localparam logic [2:0] N_DONE  = 3'd6;

  localparam int QW = fvna_pkg::NORM_BITS;

  logic [2:0]          st_q, st_d;
  logic [SUM_BITS-1:0] a_q [3];
  logic [SUM_BITS-1:0] a_d [3];
  logic [2:0]          neg_q, neg_d;
  logic [61:0]         l_q, l_d;
  logic [63:0]         n_q, n_d, res_q, res_d, bit_q, bit_d;
  logic [4:0]          cnt_q, cnt_d;
  logic [1:0]          k_q, k_d;
  logic [31:0]         rem_q, rem_d;
  logic [QW-1:0]       nlow_q, nlow_d;
  logic [QW-1:0]       q_q [3];
  logic [QW-1:0]       q_d [3];

  logic [SUM_BITS-1:0] m01, mx;
  logic [59:0]         sq;
  logic [63:0]         trial;
  logic [44:0]         numer;
  logic [31:0]         dt;
  logic [30:0]         root;
  logic                qb;
  logic [QW-1:0]       nlow_nx;

  always_comb begin
    m01 = (a_q[0] > a_q[1]) ? a_q[0] : a_q[1];
    mx  = (m01 > a_q[2]) ? m01 : a_q[2];
    sq  = a_q[k_q][29:0] * a_q[k_q][29:0];
    trial = res_q + bit_q;
    root  = res_q[30:0];
    numer = {1'b0, a_q[k_q][29:0], 14'b0} + 45'(root[30:1]);
    dt  = {rem_q[30:0], nlow_q[QW-1]};
    qb  = (dt >= {1'b0, root});
    nlow_nx = {nlow_q[QW-2:0], qb};
  end

  always_comb begin
    st_d = st_q; neg_d = neg_q; l_d = l_q; n_d = n_q; res_d = res_q; bit_d = bit_q;
    cnt_d = cnt_q; k_d = k_q; rem_d = rem_q; nlow_d = nlow_q;
    for (int i = 0; i < 3; i++) begin
      a_d[i] = a_q[i];
      q_d[i] = q_q[i];
    end
    case (st_q)
      N_IDLE: begin
        if (start_i) begin
          neg_d = {sum_z_i[SUM_BITS-1], sum_y_i[SUM_BITS-1], sum_x_i[SUM_BITS-1]};
          a_d[0] = sum_x_i[SUM_BITS-1] ? SUM_BITS'(-sum_x_i) : SUM_BITS'(sum_x_i);
          a_d[1] = sum_y_i[SUM_BITS-1] ? SUM_BITS'(-sum_y_i) : SUM_BITS'(sum_y_i);
          a_d[2] = sum_z_i[SUM_BITS-1] ? SUM_BITS'(-sum_z_i) : SUM_BITS'(sum_z_i);
          st_d = N_SHIFT;
        end
      end
      N_SHIFT: begin
        // bring the largest magnitude into [2^29, 2^30)
        if (|mx[SUM_BITS-1:30]) begin
          for (int i = 0; i < 3; i++) a_d[i] = a_q[i] >> 1;
        end else if (!mx[29]) begin
          for (int i = 0; i < 3; i++) a_d[i] = a_q[i] << 1;
        end else begin
          st_d = N_SQ;
          k_d  = 2'd0;
          l_d  = '0;
        end
      end
      N_SQ: begin
        l_d = l_q + 62'(sq);
        if (k_q == 2'd2) begin
          n_d   = 64'(l_d);
          res_d = '0;
          bit_d = 64'd1 << 62;
          cnt_d = '0;
          st_d  = N_ROOT;
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      N_ROOT: begin
        if (n_q >= trial) begin
          n_d   = n_q - trial;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          k_d  = 2'd0;
          st_d = N_DVI;
        end
      end
      N_DVI: begin
        rem_d  = 32'(numer[44:QW]);
        nlow_d = numer[QW-1:0];
        cnt_d  = '0;
        st_d   = N_DIV;
      end
      N_DIV: begin
        rem_d  = qb ? dt - {1'b0, root} : dt;
        nlow_d = nlow_nx;
        cnt_d  = cnt_q + 5'd1;
        if (cnt_q == 5'(QW-1)) begin
          q_d[k_q] = neg_q[k_q] ? QW'(-nlow_nx) : nlow_nx;
          if (k_q == 2'd2) begin
            st_d = N_DONE;
          end else begin
            k_d  = k_q + 2'd1;
            st_d = N_DVI;
          end
        end
      end
      N_DONE: st_d = N_IDLE;
      default: st_d = N_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= N_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d; l_q <= l_d; n_q <= n_d; res_q <= res_d; bit_q <= bit_d;
    cnt_q <= cnt_d; k_q <= k_d; rem_q <= rem_d; nlow_q <= nlow_d;
    for (int i = 0; i < 3; i++) begin
      a_q[i] <= a_d[i];
      q_q[i] <= q_d[i];
    end
  end

  assign res_o.done = (st_q == N_DONE);
  assign res_o.nx   = q_q[0];
  assign res_o.ny   = q_q[1];
  assign res_o.nz   = q_q[2];

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;

  localparam int NVERT = 1024;
  localparam int SUMW  = 40;
  localparam longint SUM_HI = (64'sd1 <<< (SUMW - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  logic clk_i;
  logic rst_ni;
  bit   failed;
  int   sent;

  fvna_req_if req_bus ();
  fvna_rsp_if rsp_bus ();

  fan_vertex_normal_accumulator_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus.sink),
    .rsp_o (rsp_bus.source)
  );

  // predicts normals from the same fan-triangulation and saturating sums
  class normal_scoreboard;
    longint px[NVERT], py[NVERT], pz[NVERT];
    longint sx[NVERT], sy[NVERT], sz[NVERT];
    int     fan_first, fan_prev, corners;
    fvna_pkg::rsp_t pending[$];
    int     reads, zero_reads, triangles, errors;

    function new();
      for (int i = 0; i < NVERT; i++) begin
        px[i] = 0; py[i] = 0; pz[i] = 0; sx[i] = 0; sy[i] = 0; sz[i] = 0;
      end
      fan_first = 0; fan_prev = 0; corners = 0;
    endfunction

    function longint add_sat(longint a, longint b);
      longint s;
      s = a + b;
      if (s > SUM_HI) return SUM_HI;
      if (s < SUM_LO) return SUM_LO;
      return s;
    endfunction

    function longint unsigned root(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else r = r >> 1;
        b = b >> 2;
      end
      return r;
    endfunction

    function void add_triangle(int i0, int i1, int i2);
      longint ax, ay, az, bx, by, bz, cx, cy, cz;
      int t[3];
      ax = px[i1] - px[i0]; ay = py[i1] - py[i0]; az = pz[i1] - pz[i0];
      bx = px[i2] - px[i0]; by = py[i2] - py[i0]; bz = pz[i2] - pz[i0];
      cx = ay * bz - az * by;
      cy = az * bx - ax * bz;
      cz = ax * by - ay * bx;
      t[0] = i0; t[1] = i1; t[2] = i2;
      foreach (t[k]) begin
        sx[t[k]] = add_sat(sx[t[k]], cx);
        sy[t[k]] = add_sat(sy[t[k]], cy);
        sz[t[k]] = add_sat(sz[t[k]], cz);
      end
      triangles++;
    endfunction

    function fvna_pkg::rsp_t normalize(int idx);
      fvna_pkg::rsp_t r;
      longint s[3];
      longint unsigned a[3], m, l, rt, q;
      s[0] = sx[idx]; s[1] = sy[idx]; s[2] = sz[idx];
      r = '0;
      r.read_vertex = idx[fvna_pkg::IDX_BITS-1:0];
      if (s[0] == 0 && s[1] == 0 && s[2] == 0) begin
        r.was_zero = 1'b1;
        return r;
      end
      m = 0;
      foreach (s[k]) begin
        a[k] = (s[k] < 0) ? -s[k] : s[k];
        if (a[k] > m) m = a[k];
      end
      while (m >= (64'd1 << 30)) begin
        m = m >> 1;
        foreach (a[k]) a[k] = a[k] >> 1;
      end
      while (m < (64'd1 << 29)) begin
        m = m << 1;
        foreach (a[k]) a[k] = a[k] << 1;
      end
      l = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
      rt = root(l);
      q = (16384 * a[0] + rt / 2) / rt;
      r.normal_x = (s[0] < 0) ? -q[15:0] : q[15:0];
      q = (16384 * a[1] + rt / 2) / rt;
      r.normal_y = (s[1] < 0) ? -q[15:0] : q[15:0];
      q = (16384 * a[2] + rt / 2) / rt;
      r.normal_z = (s[2] < 0) ? -q[15:0] : q[15:0];
      return r;
    endfunction

    function void note_request(fvna_pkg::req_t q);
      int idx;
      idx = q.vertex_index;
      case (q.func)
        fvna_pkg::FUNC_LOAD: begin
          px[idx] = q.pos_x; py[idx] = q.pos_y; pz[idx] = q.pos_z;
          sx[idx] = 0; sy[idx] = 0; sz[idx] = 0;
        end
        fvna_pkg::FUNC_CORNER: begin
          if (corners == 0) begin
            fan_first = idx; corners = 1;
          end else if (corners == 1) begin
            fan_prev = idx; corners = 2;
          end else begin
            add_triangle(fan_first, fan_prev, idx);
            fan_prev = idx;
          end
          if (q.corner_last) corners = 0;
        end
        fvna_pkg::FUNC_READ: begin
          pending = {pending, normalize(idx)};
          reads++;
        end
        default: ;
      endcase
    endfunction

    function void check_result(fvna_pkg::rsp_t got);
      fvna_pkg::rsp_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected normal for vertex %0d", $time, got.read_vertex);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (want.was_zero) zero_reads++;
      if (got !== want) begin
        $display("%0t: normal mismatch expected v%0d (%0d,%0d,%0d) z%0b",
                 $time, want.read_vertex, want.normal_x, want.normal_y, want.normal_z,
                 want.was_zero);
        $display("%0t:                 got      v%0d (%0d,%0d,%0d) z%0b",
                 $time, got.read_vertex, got.normal_x, got.normal_y, got.normal_z,
                 got.was_zero);
        errors++;
      end
    endfunction
  endclass

  normal_scoreboard sb;
  bit loaded[NVERT];
  int loaded_list[$];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("fan_vertex_normal_accumulator_top regression: fail");
    $finish;
  end

  function int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // response side: random back-pressure, compared on each accepted response
  initial begin
    int g;
    rsp_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_bus.valid && rsp_bus.ready) sb.check_result(rsp_bus.data);
      g = gap_len();
      rsp_bus.ready <= (g == 0) || ($urandom_range(0, 3) == 0);
    end
  end

  // valid stays high across back-to-back requests and drops only for a gap
  task automatic send(fvna_pkg::req_t q);
    int g;
    g = gap_len();
    if (g != 0) begin
      req_bus.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    req_bus.valid <= 1'b1;
    req_bus.data  <= q;
    do @(posedge clk_i); while (!req_bus.ready);
    sb.note_request(q);
    sent++;
    if (q.func == fvna_pkg::FUNC_LOAD && !loaded[q.vertex_index]) begin
      loaded[q.vertex_index] = 1'b1;
      loaded_list = {loaded_list, int'(q.vertex_index)};
    end
  endtask

  function fvna_pkg::req_t mk(logic [1:0] f, int idx, int x = 0, int y = 0, int z = 0,
                              bit last = 0);
    fvna_pkg::req_t q;
    q.func = f;
    q.vertex_index = idx[fvna_pkg::IDX_BITS-1:0];
    q.pos_x = x[15:0]; q.pos_y = y[15:0]; q.pos_z = z[15:0];
    q.corner_last = last;
    return q;
  endfunction

  function int any_loaded();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  task automatic drain();
    int t;
    t = 0;
    req_bus.valid <= 1'b0;
    do begin
      @(posedge clk_i);
      t++;
    end while (sb.pending.size() != 0 && t < 200000);
  endtask

  task automatic random_polygon();
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++)
      send(mk(fvna_pkg::FUNC_CORNER, any_loaded(), 0, 0, 0, i == n - 1));
  endtask

  task automatic random_load(bit extreme);
    int x, y, z;
    if (extreme) begin
      x = $urandom_range(0, 1) ? 32767 : -32768;
      y = $urandom_range(0, 1) ? 32767 : -32768;
      z = $urandom_range(0, 1) ? 32767 : -32768;
    end else begin
      x = $urandom; y = $urandom; z = $urandom;
    end
    // mostly a small pool so polygons share vertices
    send(mk(fvna_pkg::FUNC_LOAD, $urandom_range(0, 3) == 0 ? $urandom_range(0, NVERT - 1)
                                                           : $urandom_range(0, 31), x, y, z));
  endtask

  initial begin
    int n;
    sb = new();
    sent = 0;
    rst_ni = 1'b0;
    req_bus.valid <= 1'b0;
    req_bus.data  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, degenerate polygons, zero sum
    send(mk(fvna_pkg::FUNC_LOAD, 0, 0, 0, 0));
    send(mk(fvna_pkg::FUNC_LOAD, 1, 32767, 0, 0));
    send(mk(fvna_pkg::FUNC_LOAD, 2, 0, 32767, 0));
    send(mk(fvna_pkg::FUNC_LOAD, 1023, -32768, -32768, 32767));
    send(mk(fvna_pkg::FUNC_LOAD, 3, -32768, 32767, -32768));
    send(mk(fvna_pkg::FUNC_READ, 0));
    send(mk(fvna_pkg::FUNC_CORNER, 0, 0, 0, 0, 1));
    send(mk(fvna_pkg::FUNC_CORNER, 1)); send(mk(fvna_pkg::FUNC_CORNER, 2, 0, 0, 0, 1));
    send(mk(fvna_pkg::FUNC_READ, 0));
    send(mk(fvna_pkg::FUNC_CORNER, 0)); send(mk(fvna_pkg::FUNC_CORNER, 1));
    send(mk(fvna_pkg::FUNC_READ, 2));
    send(mk(fvna_pkg::FUNC_CORNER, 2)); send(mk(fvna_pkg::FUNC_CORNER, 3));
    send(mk(fvna_pkg::FUNC_CORNER, 1023, 0, 0, 0, 1));
    send(mk(FUNC_NONE, 1023, -1, -1, -1, 1));
    for (int i = 0; i < 3; i++) begin
      send(mk(fvna_pkg::FUNC_CORNER, 1023)); send(mk(fvna_pkg::FUNC_CORNER, 3));
      send(mk(fvna_pkg::FUNC_CORNER, 0, 0, 0, 0, 1));
    end
    send(mk(fvna_pkg::FUNC_READ, 1023));
    send(mk(fvna_pkg::FUNC_READ, 1));
    send(mk(fvna_pkg::FUNC_READ, 3));
    drain();

    n = 0;
    while (sent < 400) begin
      int p;
      p = $urandom_range(0, 99);
      if (loaded_list.size() < 4 || p < 20) random_load($urandom_range(0, 9) == 0);
      else if (p < 55) random_polygon();
      else if (p < 90) send(mk(fvna_pkg::FUNC_READ, any_loaded()));
      else if (p < 94) send(mk(FUNC_NONE, $urandom, $urandom, $urandom, $urandom,
                               $urandom_range(0, 1)));
      else if (p < 97) send(mk(fvna_pkg::FUNC_CORNER, any_loaded(), 0, 0, 0, 1));
      else send(mk(fvna_pkg::FUNC_READ, $urandom_range(0, NVERT - 1))); // may be unloaded
      if (n == 80) drain();
      n++;
    end

    drain();
    repeat (300) @(posedge clk_i);
    failed = (sb.errors != 0) || (sb.pending.size() != 0);
    if (sb.pending.size() != 0)
      $display("%0t: %0d normals never arrived", $time, sb.pending.size());
    $display("covered %0d requests: %0d reads (%0d zero sums) and %0d fan triangles",
             sent, sb.reads, sb.zero_reads, sb.triangles);
    $display("over %0d loaded vertices", loaded_list.size());
    if (!failed) $display("fan_vertex_normal_accumulator_top regression: pass");
    else $display("fan_vertex_normal_accumulator_top regression: fail");
    $finish;
  end
endmodule

FILE: fan_vertex_normal_accumulator_top.f
rtl/fvna_pkg.sv
rtl/fvna_if.sv
rtl/fvna_ram.sv
rtl/fvna_norm.sv
rtl/fan_vertex_normal_accumulator_top.sv
tb/sv/tb_top.sv
